### hw/rtl/rmdi_pkg.sv
// Shared types, constants and register codes of the ray-march density integrator.
`default_nettype none

package rmdi_pkg;

    // Samples taken along each ray chord.
    localparam int STEPS = 40;
    localparam int I_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    // Field and datapath widths.
    localparam int COORD_W  = 20;   // Q3.16 signed input coordinate
    localparam int SMAX_W   = 26;   // exit distance, Q.16
    localparam int DS_W     = 26;   // step length, Q.16
    localparam int DV_W     = DS_W + 1 + COORD_W; // step vector, Q.32 signed
    localparam int P_W      = 48;   // sample point, Q.32 signed
    localparam int MAG_W    = 25;   // clamped coordinate magnitude, Q.16
    localparam int SQ_W     = 2 * MAG_W;
    localparam int R2_W     = SQ_W + 2;
    localparam int XP_W     = R2_W + 16;
    localparam int X_W      = 48;   // divisor width, holds 2^32 + X_MAX
    localparam int QUO_W    = 57;   // 2^56 / x quotient
    localparam int ACC_W    = 53;
    localparam int INT_W    = 26;
    localparam int RECIP_W  = 33;

    localparam int SQRT_ITERS = 25;
    localparam int SQRT_J_W   = $clog2(SQRT_ITERS);
    localparam int DIV_STAGES = QUO_W;

    localparam logic [X_W-1:0]     X_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [X_W-1:0]     ONE_Q32 = 48'h0001_0000_0000;
    localparam logic [ACC_W-1:0]   ACC_MAX = {ACC_W{1'b1}};
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << 32) / STEPS);

    // Front to back queue.
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CFG_INV_CORE_SQ   = 2'd0,
        CFG_MIN_SCALED_R2 = 2'd1,
        CFG_GAIN          = 2'd2,
        CFG_CEILING       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic             hit;
    } t_res;

    typedef struct packed {
        logic [15:0] inv_core_sq;
        logic [31:0] min_scaled_r2;
        logic [9:0]  gain;
        logic [9:0]  ceiling;
    } t_cfg;

    // One classified ray handed from front to back.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][DV_W-1:0]    dv;
        logic [DS_W-1:0]         ds;
        logic                    hit;
    } t_job;

    // Per-sample side information riding down the back pipeline.
    typedef struct packed {
        logic            first;
        logic            last;
        logic            hit;
        logic [DS_W-1:0] ds;
    } t_tag;

    typedef enum logic [3:0] {
        F_IDLE,
        F_DOT,
        F_SQB,
        F_DISC,
        F_SQRT,
        F_SMAX,
        F_DIVQ,
        F_DIVC,
        F_DV,
        F_PUSH
    } t_fstate;

endpackage

`default_nettype wire

### hw/rtl/rmdi_queue.sv
// Short job queue between the classifying front and the sampling back.
`default_nettype none

module rmdi_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rmdi_pkg::t_job     i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output rmdi_pkg::t_job     o_data
);

    rmdi_pkg::t_job                r_mem [0:rmdi_pkg::QDEPTH-1];
    logic [rmdi_pkg::QAW-1:0]      r_wp;
    logic [rmdi_pkg::QAW-1:0]      r_rp;
    logic [rmdi_pkg::QCW-1:0]      r_cnt;

    function automatic logic [rmdi_pkg::QAW-1:0] ptr_inc(input logic [rmdi_pkg::QAW-1:0] p);
        return (p == rmdi_pkg::QAW'(rmdi_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == rmdi_pkg::QCW'(rmdi_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rmdi_front.sv
// Ray front end: sphere intersection, exit distance and step vector per ray.
`default_nettype none

module rmdi_front (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    output logic           o_busy,
    input  rmdi_pkg::t_ray i_ray,
    input  wire logic      i_q_full,
    output logic           o_push,
    output rmdi_pkg::t_job o_job
);

    rmdi_pkg::t_fstate r_state;
    rmdi_pkg::t_fstate n_state;

    logic signed [rmdi_pkg::COORD_W-1:0] r_s [0:2];
    logic signed [rmdi_pkg::COORD_W-1:0] r_d [0:2];
    logic [1:0]                          r_k;
    logic signed [41:0]                  r_b32;
    logic [41:0]                         r_n2;
    logic [49:0]                         r_bsq;
    logic [49:0]                         r_rem;
    logic [49:0]                         r_res;
    logic [rmdi_pkg::SQRT_J_W-1:0]       r_j;
    logic [rmdi_pkg::SMAX_W-1:0]         r_smax;
    logic [26:0]                         r_q;
    logic [rmdi_pkg::DS_W-1:0]           r_ds;
    logic signed [rmdi_pkg::DV_W-1:0]    r_dv [0:2];
    logic                                r_hit;

    logic                                accept;
    logic signed [39:0]                  dot_sd;
    logic signed [39:0]                  sq_s;
    logic signed [25:0]                  b16;
    logic signed [51:0]                  b16_sq;
    logic signed [51:0]                  dd;
    logic                                dd_pos;
    logic [49:0]                         sq_bit;
    logic [49:0]                         sq_trial;
    logic                                sq_ge;
    logic signed [26:0]                  smax_c;
    logic                                smax_pos;
    logic [58:0]                         qprod;
    logic [27:0]                         qs;
    logic [27:0]                         dv_rem;
    logic [rmdi_pkg::DS_W-1:0]           ds_c;
    logic signed [rmdi_pkg::DV_W-1:0]    dv_prod;

    assign accept   = i_start && !o_busy;
    assign dot_sd   = r_s[r_k] * r_d[r_k];
    assign sq_s     = r_s[r_k] * r_s[r_k];
    assign b16      = r_b32[41:16];            // floor to Q.16
    assign b16_sq   = b16 * b16;
    assign dd       = $signed({2'b00, r_bsq}) + 52'sh1_0000_0000 - $signed({10'b0, r_n2});
    assign dd_pos   = !dd[51] && (dd != '0);
    assign sq_bit   = 50'(1) << {r_j, 1'b0};
    assign sq_trial = r_res + sq_bit;
    assign sq_ge    = (r_rem >= sq_trial);
    assign smax_c   = $signed({2'b00, r_res[24:0]}) - 27'(b16);
    assign smax_pos = !smax_c[26] && (smax_c != '0);
    // smax / STEPS: reciprocal estimate is exact or one low
    assign qprod    = r_smax * rmdi_pkg::RECIP;
    assign qs       = 28'(r_q * rmdi_pkg::STEPS);
    assign dv_rem   = {2'b00, r_smax} - qs;
    assign ds_c     = (dv_rem >= 28'(rmdi_pkg::STEPS)) ? rmdi_pkg::DS_W'(r_q + 1'b1)
                                                        : r_q[rmdi_pkg::DS_W-1:0];
    assign dv_prod  = $signed({1'b0, r_ds}) * r_d[r_k];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmdi_pkg::F_IDLE: if (accept) n_state = rmdi_pkg::F_DOT;
            rmdi_pkg::F_DOT:  if (r_k == 2'd2) n_state = rmdi_pkg::F_SQB;
            rmdi_pkg::F_SQB:  n_state = rmdi_pkg::F_DISC;
            rmdi_pkg::F_DISC: n_state = dd_pos ? rmdi_pkg::F_SQRT : rmdi_pkg::F_PUSH;
            rmdi_pkg::F_SQRT: if (r_j == '0) n_state = rmdi_pkg::F_SMAX;
            rmdi_pkg::F_SMAX: n_state = smax_pos ? rmdi_pkg::F_DIVQ : rmdi_pkg::F_PUSH;
            rmdi_pkg::F_DIVQ: n_state = rmdi_pkg::F_DIVC;
            rmdi_pkg::F_DIVC: n_state = rmdi_pkg::F_DV;
            rmdi_pkg::F_DV:   if (r_k == 2'd2) n_state = rmdi_pkg::F_PUSH;
            rmdi_pkg::F_PUSH: if (!i_q_full) n_state = rmdi_pkg::F_IDLE;
            default:          n_state = rmdi_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != rmdi_pkg::F_IDLE);
        o_push = (r_state == rmdi_pkg::F_PUSH) && !i_q_full;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_job.s[k]  = r_s[k];
            o_job.dv[k] = r_dv[k];
        end
        o_job.ds  = r_ds;
        o_job.hit = r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmdi_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rmdi_pkg::F_IDLE: begin
                if (accept) begin
                    r_s[0] <= i_ray.start_x;
                    r_s[1] <= i_ray.start_y;
                    r_s[2] <= i_ray.start_z;
                    r_d[0] <= i_ray.dir_x;
                    r_d[1] <= i_ray.dir_y;
                    r_d[2] <= i_ray.dir_z;
                    r_k    <= '0;
                    r_b32  <= '0;
                    r_n2   <= '0;
                end
            end
            rmdi_pkg::F_DOT: begin
                r_b32 <= r_b32 + 42'(dot_sd);
                r_n2  <= r_n2 + 42'($unsigned(sq_s));
                r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            rmdi_pkg::F_SQB: begin
                r_bsq <= b16_sq[49:0];
            end
            rmdi_pkg::F_DISC: begin
                r_rem <= dd[49:0];
                r_res <= '0;
                r_j   <= rmdi_pkg::SQRT_J_W'(rmdi_pkg::SQRT_ITERS - 1);
                r_hit <= dd_pos;
                if (!dd_pos) begin
                    r_ds <= '0;
                    for (int k = 0; k < 3; k++) r_dv[k] <= '0;
                end
            end
            rmdi_pkg::F_SQRT: begin
                if (sq_ge) begin
                    r_rem <= r_rem - sq_trial;
                    r_res <= (r_res >> 1) + sq_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_j <= r_j - 1'b1;
            end
            rmdi_pkg::F_SMAX: begin
                r_smax <= smax_c[rmdi_pkg::SMAX_W-1:0];
                r_hit  <= smax_pos;
                if (!smax_pos) begin
                    r_ds <= '0;
                    for (int k = 0; k < 3; k++) r_dv[k] <= '0;
                end
            end
            rmdi_pkg::F_DIVQ: begin
                r_q <= qprod[58:32];
            end
            rmdi_pkg::F_DIVC: begin
                r_ds <= ds_c;
                r_k  <= '0;
            end
            rmdi_pkg::F_DV: begin
                r_dv[r_k] <= dv_prod;
                r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            rmdi_pkg::F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/rmdi_recip.sv
// Dual-lane pipelined reciprocal: 2^56 / d for two divisors, one bit per stage.
`default_nettype none

module rmdi_recip (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    input  wire logic [rmdi_pkg::X_W-1:0]     i_den1,
    input  wire logic [rmdi_pkg::X_W-1:0]     i_den2,
    input  rmdi_pkg::t_tag                    i_tag,
    output logic                              o_vld,
    output logic [rmdi_pkg::QUO_W-1:0]        o_quo1,
    output logic [rmdi_pkg::QUO_W-1:0]        o_quo2,
    output rmdi_pkg::t_tag                    o_tag
);

    localparam int NS = rmdi_pkg::DIV_STAGES;
    localparam int XW = rmdi_pkg::X_W;
    localparam int QW = rmdi_pkg::QUO_W;

    logic          r_vld  [0:NS-1];
    logic [XW-1:0] r_den1 [0:NS-1];
    logic [XW-1:0] r_den2 [0:NS-1];
    logic [XW-1:0] r_rem1 [0:NS-1];
    logic [XW-1:0] r_rem2 [0:NS-1];
    logic [QW-1:0] r_quo1 [0:NS-1];
    logic [QW-1:0] r_quo2 [0:NS-1];
    rmdi_pkg::t_tag r_tag [0:NS-1];

    // returns {quotient bit, new remainder}
    function automatic logic [XW:0] div_step(input logic [XW-1:0] rem,
                                             input logic [XW-1:0] den,
                                             input logic          bin);
        logic [XW:0] sh;
        logic [XW:0] df;
        sh = {rem, bin};
        df = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {1'b1, df[XW-1:0]};
        end
        return {1'b0, sh[XW-1:0]};
    endfunction

    logic [XW:0] st1 [0:NS-1];
    logic [XW:0] st2 [0:NS-1];

    always_comb begin
        // leading dividend bit is the only one set
        st1[0] = div_step('0, i_den1, 1'b1);
        st2[0] = div_step('0, i_den2, 1'b1);
        for (int j = 1; j < NS; j++) begin
            st1[j] = div_step(r_rem1[j-1], r_den1[j-1], 1'b0);
            st2[j] = div_step(r_rem2[j-1], r_den2[j-1], 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_den1[0] <= i_den1;
        r_den2[0] <= i_den2;
        r_rem1[0] <= st1[0][XW-1:0];
        r_rem2[0] <= st2[0][XW-1:0];
        r_quo1[0] <= QW'(st1[0][XW]);
        r_quo2[0] <= QW'(st2[0][XW]);
        r_tag[0]  <= i_tag;
        for (int j = 1; j < NS; j++) begin
            r_den1[j] <= r_den1[j-1];
            r_den2[j] <= r_den2[j-1];
            r_rem1[j] <= st1[j][XW-1:0];
            r_rem2[j] <= st2[j][XW-1:0];
            r_quo1[j] <= {r_quo1[j-1][QW-2:0], st1[j][XW]};
            r_quo2[j] <= {r_quo2[j-1][QW-2:0], st2[j][XW]};
            r_tag[j]  <= r_tag[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NS; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int j = 1; j < NS; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo1 = r_quo1[NS-1];
    assign o_quo2 = r_quo2[NS-1];
    assign o_tag  = r_tag[NS-1];

endmodule

`default_nettype wire

### hw/rtl/rmdi_back.sv
// Ray back end: sample sequencer, density pipeline, accumulator and final scaling.
`default_nettype none

module rmdi_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_valid,
    input  rmdi_pkg::t_job i_job,
    output logic           o_pop,
    input  rmdi_pkg::t_cfg i_cfg,
    output logic           o_res_valid,
    output rmdi_pkg::t_res o_res
);

    // sequencer
    logic                             r_run;
    logic [rmdi_pkg::I_W-1:0]         r_i;
    logic signed [rmdi_pkg::P_W-1:0]  r_p  [0:2];
    logic signed [rmdi_pkg::DV_W-1:0] r_dv [0:2];
    logic [rmdi_pkg::DS_W-1:0]        r_ds;
    logic                             r_hit;
    logic                             last_issue;

    // density pipeline
    logic                             r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    rmdi_pkg::t_tag                   r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag, r_s6_tag;
    logic [rmdi_pkg::MAG_W-1:0]       r_s1_mag [0:2];
    logic [rmdi_pkg::SQ_W-1:0]        r_s2_sq  [0:2];
    logic [rmdi_pkg::R2_W-1:0]        r_s3_r2;
    logic [rmdi_pkg::XP_W-1:0]        r_s4_xp;
    logic [rmdi_pkg::X_W-2:0]         r_s5_xs;
    logic [rmdi_pkg::X_W-1:0]         r_s6_d1;
    logic [rmdi_pkg::X_W-1:0]         r_s6_d2;

    logic [rmdi_pkg::MAG_W-1:0]       mag_c [0:2];
    logic [31:0]                      floor_x;
    logic [rmdi_pkg::X_W-1:0]         d1_c;

    // reciprocal outputs
    logic                             rc_vld;
    logic [rmdi_pkg::QUO_W-1:0]       rc_q1;
    logic [rmdi_pkg::QUO_W-1:0]       rc_q2;
    rmdi_pkg::t_tag                   rc_tag;

    // accumulator and final scaling
    logic [rmdi_pkg::ACC_W-1:0]       r_acc;
    logic [rmdi_pkg::ACC_W-1:0]       acc_base;
    logic [rmdi_pkg::QUO_W:0]         acc_sum;
    logic [rmdi_pkg::QUO_W-1:0]       term;
    logic                             r_g_vld;
    logic                             r_g_hit;
    logic [rmdi_pkg::DS_W-1:0]        r_g_ds;
    logic                             r_h1_vld, r_h2_vld, r_h3_vld;
    logic                             r_h1_hit, r_h2_hit, r_h3_hit;
    logic [52:0]                      r_h1_pl;
    logic [51:0]                      r_h1_ph;
    logic [78:0]                      r_h2_prod;
    logic [49:0]                      r_h3_glo;
    logic [48:0]                      r_h3_ghi;
    logic [88:0]                      tot;
    logic [64:0]                      m_c;
    logic [rmdi_pkg::INT_W-1:0]       lim;
    logic                             r_out_vld;
    rmdi_pkg::t_res                   r_out;

    assign last_issue = r_run && (r_i == rmdi_pkg::I_W'(rmdi_pkg::STEPS - 1));
    assign o_pop      = i_q_valid && (!r_run || last_issue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (o_pop) begin
            r_run <= 1'b1;
        end else if (last_issue) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_i   <= '0;
            r_ds  <= i_job.ds;
            r_hit <= i_job.hit;
            for (int k = 0; k < 3; k++) begin
                r_p[k]  <= rmdi_pkg::P_W'($signed(i_job.s[k])) <<< 16;
                r_dv[k] <= $signed(i_job.dv[k]);
            end
        end else if (r_run) begin
            r_i <= r_i + 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= r_p[k] + rmdi_pkg::P_W'(r_dv[k]);
            end
        end
    end

    // floor to Q.16, magnitude clamped at 256
    always_comb begin
        logic signed [31:0] crd;
        logic [31:0]        mg;
        for (int k = 0; k < 3; k++) begin
            crd = r_p[k][47:16];
            mg  = crd[31] ? 32'(-crd) : 32'(crd);
            mag_c[k] = (mg > 32'h0100_0000) ? 25'h100_0000 : mg[rmdi_pkg::MAG_W-1:0];
        end
    end

    assign floor_x = (i_cfg.min_scaled_r2 == '0) ? 32'd1 : i_cfg.min_scaled_r2;
    assign d1_c    = ({1'b0, r_s5_xs} < {16'b0, floor_x}) ? {16'b0, floor_x} : {1'b0, r_s5_xs};

    always_ff @(posedge i_clk) begin
        r_s1_tag <= '{first: (r_i == '0), last: last_issue, hit: r_hit, ds: r_ds};
        for (int k = 0; k < 3; k++) begin
            r_s1_mag[k] <= mag_c[k];
            r_s2_sq[k]  <= r_s1_mag[k] * r_s1_mag[k];
        end
        r_s2_tag <= r_s1_tag;
        r_s3_r2  <= rmdi_pkg::R2_W'(r_s2_sq[0]) + rmdi_pkg::R2_W'(r_s2_sq[1])
                  + rmdi_pkg::R2_W'(r_s2_sq[2]);
        r_s3_tag <= r_s2_tag;
        r_s4_xp  <= r_s3_r2 * i_cfg.inv_core_sq;
        r_s4_tag <= r_s3_tag;
        r_s5_xs  <= (r_s4_xp > rmdi_pkg::XP_W'(rmdi_pkg::X_MAX)) ? rmdi_pkg::X_MAX[46:0]
                                                                   : r_s4_xp[46:0];
        r_s5_tag <= r_s4_tag;
        r_s6_d1  <= d1_c;
        r_s6_d2  <= d1_c + rmdi_pkg::ONE_Q32;
        r_s6_tag <= r_s5_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_run;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    rmdi_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s6_vld),
        .i_den1  (r_s6_d1),
        .i_den2  (r_s6_d2),
        .i_tag   (r_s6_tag),
        .o_vld   (rc_vld),
        .o_quo1  (rc_q1),
        .o_quo2  (rc_q2),
        .o_tag   (rc_tag)
    );

    // 1/x - 1/(1+x), saturating sum
    assign term     = rc_q1 - rc_q2;
    assign acc_base = rc_tag.first ? '0 : r_acc;
    assign acc_sum  = (rmdi_pkg::QUO_W+1)'(acc_base) + (rmdi_pkg::QUO_W+1)'(term);

    always_ff @(posedge i_clk) begin
        if (rc_vld) begin
            r_acc <= (acc_sum > (rmdi_pkg::QUO_W+1)'(rmdi_pkg::ACC_MAX))
                   ? rmdi_pkg::ACC_MAX : acc_sum[rmdi_pkg::ACC_W-1:0];
            r_g_hit <= rc_tag.hit;
            r_g_ds  <= rc_tag.ds;
        end
    end

    // acc * ds * gain / 2^24 in split partial products
    assign tot = {r_h3_ghi, 40'b0} + 89'(r_h3_glo);
    assign m_c = tot[88:24];
    assign lim = {i_cfg.ceiling, 16'b0};

    always_ff @(posedge i_clk) begin
        r_h1_pl   <= r_acc[26:0] * r_g_ds;
        r_h1_ph   <= r_acc[52:27] * r_g_ds;
        r_h1_hit  <= r_g_hit;
        r_h2_prod <= {r_h1_ph, 27'b0} + 79'(r_h1_pl);
        r_h2_hit  <= r_h1_hit;
        r_h3_glo  <= r_h2_prod[39:0] * i_cfg.gain;
        r_h3_ghi  <= r_h2_prod[78:40] * i_cfg.gain;
        r_h3_hit  <= r_h2_hit;
        r_out.hit <= r_h3_hit;
        if (!r_h3_hit) begin
            r_out.intensity <= '0;
        end else if (m_c > 65'(lim)) begin
            r_out.intensity <= lim;
        end else begin
            r_out.intensity <= m_c[rmdi_pkg::INT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld   <= 1'b0;
            r_h1_vld  <= 1'b0;
            r_h2_vld  <= 1'b0;
            r_h3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_g_vld   <= rc_vld && rc_tag.last;
            r_h1_vld  <= r_g_vld;
            r_h2_vld  <= r_h1_vld;
            r_h3_vld  <= r_h2_vld;
            r_out_vld <= r_h3_vld;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

`default_nettype wire

### hw/rtl/ray_march_density_integrator.sv
// Top level of the ray-march density integrator: config registers, front, queue, back.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+----------------------------------
//  ray     | in        | transfer when start && !busy  | i_ray (start_xyz, dir_xyz, Q3.16)
//  result  | out       | o_res_valid strobe, one cycle | o_res (intensity Q10.16, hit)
//  config  | in        | i_cfg_valid && o_cfg_ready    | i_cfg_index, i_cfg_data
//
// The back end runs one density sample per cycle and takes the next queued ray as
// it issues the last sample of the current one; the front end spends most of its
// time on the 25-iteration square root, and overlaps the back. From the queue a ray
// passes the sample pipeline, the 57-stage reciprocal, the accumulator, three
// scaling stages and the output register before its result is strobed.
// Reset is synchronous, active low, clears control state and loads the config defaults; no clearing pass.
// busy rises while the front works on a ray or cannot hand it on; the result side
// never stalls, every result is strobed once.
`default_nettype none

module ray_march_density_integrator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  rmdi_pkg::t_ray   i_ray,
    output logic             o_res_valid,
    output rmdi_pkg::t_res   o_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    rmdi_pkg::t_cfg r_cfg;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    rmdi_pkg::t_job front_job;
    rmdi_pkg::t_job back_job;

    // registers are always writable; writes must only come while idle, the block itself does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_core_sq   <= 16'd400;
            r_cfg.min_scaled_r2 <= 32'd1074;
            r_cfg.gain          <= 10'd60;
            r_cfg.ceiling       <= 10'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rmdi_pkg::t_cfg_idx'(i_cfg_index))
                rmdi_pkg::CFG_INV_CORE_SQ:   r_cfg.inv_core_sq   <= i_cfg_data[15:0];
                rmdi_pkg::CFG_MIN_SCALED_R2: r_cfg.min_scaled_r2 <= i_cfg_data;
                rmdi_pkg::CFG_GAIN:          r_cfg.gain          <= i_cfg_data[9:0];
                rmdi_pkg::CFG_CEILING:       r_cfg.ceiling       <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Front: dot products, discriminant, square root, step length and step vector.
    rmdi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_ray    (i_ray),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    // Two-deep queue lets the front start the next ray while the back samples.
    rmdi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (back_job)
    );

    // Back: STEPS samples per ray, missed rays too (their result is forced to zero).
    rmdi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (back_job),
        .o_pop       (q_pop),
        .i_cfg       (r_cfg),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### hw/rtl/rmdi_checker.sv
// Port-level assertions for the ray-march density integrator, bound to the top level.
`default_nettype none

module rmdi_port_props (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_res_valid,
    input rmdi_pkg::t_res o_res
);

    // an accepted ray occupies the front on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a ray transfer");

    // a missed ray carries no intensity
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.hit |-> o_res.intensity == '0)
        else $error("miss reported with nonzero intensity");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_res_valid)
        else $error("block not idle after reset");

endmodule

bind ray_march_density_integrator rmdi_port_props u_rmdi_port_props (.*);

`default_nettype wire
